// ===== hw/rtl/ggl_pkg.sv =====
// Shared constants, types and the line error function of the grid line walk unit.
// No dependencies; every other file of the unit imports this package.
package ggl_pkg;

   localparam int GRID_SIDE         = 16;
   localparam int COORD_W           = $clog2(GRID_SIDE);
   localparam int STORE_DEPTH       = 2 * GRID_SIDE;
   localparam int GIVE_UP_POSITIONS = 256;
   localparam int LEN_LIMIT         = (STORE_DEPTH < GIVE_UP_POSITIONS) ? STORE_DEPTH :
                                      GIVE_UP_POSITIONS;
   localparam int IDX_W             = $clog2(STORE_DEPTH);
   localparam int LEN_W             = IDX_W + 1;
   localparam int NUM_BANKS         = 2;
   localparam int MEM_DEPTH         = NUM_BANKS * STORE_DEPTH;
   localparam int MEM_ADDR_W        = $clog2(MEM_DEPTH);
   localparam int QUEUE_DEPTH       = NUM_BANKS;
   localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
   localparam int DELTA_W           = COORD_W + 2;
   localparam int SPOS_W            = COORD_W + 3;
   localparam int ERR_W             = 2 * SPOS_W;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } cell_type;

   typedef struct packed {
      logic                  en;
      logic [MEM_ADDR_W-1:0] addr;
      cell_type              data;
   } wr_port_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             failed;
      logic             bank;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // A coordinate at or above the grid side is pulled back onto the last column or row.
   function automatic coord_type clamp_coord(input coord_type v);
      clamp_coord = (int'(v) >= GRID_SIDE) ? coord_type'(GRID_SIDE - 1) : v;
   endfunction

   // Distance of a candidate cell from the ideal line, scaled by the line
   // length: |(cy - ty) * dx - (cx - tx) * dy|.
   function automatic logic [ERR_W-1:0] line_err(
      input logic signed [SPOS_W-1:0]  cy_off,
      input logic signed [SPOS_W-1:0]  cx_off,
      input logic signed [DELTA_W-1:0] dx,
      input logic signed [DELTA_W-1:0] dy);
      logic signed [ERR_W-1:0] p;
      logic signed [ERR_W-1:0] q;
      logic signed [ERR_W-1:0] e;
      p = $signed(ERR_W'(cy_off)) * $signed(ERR_W'(dx));
      q = $signed(ERR_W'(cx_off)) * $signed(ERR_W'(dy));
      e = p - q;
      line_err = e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
   endfunction

endpackage

// ===== hw/rtl/ggl_chan_if.sv =====
// Request and response channel interfaces of the grid line walk unit.
// Depends on ggl_pkg for the coordinate width.
interface ggl_req_if import ggl_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;

   modport source (output valid, output start_x, output start_y, output end_x,
                   output end_y, input ready);
   modport sink (input valid, input start_x, input start_y, input end_x,
                 input end_y, output ready);
endinterface

interface ggl_rsp_if import ggl_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type cell_x;
   coord_type cell_y;
   logic      last;
   logic      failed;

   modport source (output valid, output cell_x, output cell_y, output last,
                   output failed, input ready);
   modport sink (input valid, input cell_x, input cell_y, input last,
                 input failed, output ready);
endinterface

// ===== hw/rtl/ggl_walker.sv =====
// Front end: accepts a line request and walks it one cell per cycle into a path bank.
// Depends on ggl_pkg and ggl_chan_if; feeds ggl_queue and the path memory in ggl_emitter.
module ggl_walker import ggl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ggl_req_if.sink      req_chan,
   input  qstat_type    qstat,
   output logic         push,
   output desc_type     push_desc,
   output wr_port_type  wr_port
);

   typedef enum logic {W_IDLE, W_STEP} walk_state_type;

   walk_state_type             state_ff;
   coord_type                  px_ff, py_ff, tx_ff, ty_ff;
   logic signed [DELTA_W-1:0]  dx_ff, dy_ff;
   logic [LEN_W-1:0]           len_ff;
   logic                       bank_ff;

   logic                       accept;
   coord_type                  fx_c, fy_c, tx_c, ty_c;
   logic signed [SPOS_W-1:0]   px_s, py_s, tx_s, ty_s, sx_s, sy_s, x1_s, y1_s;
   logic                       ok0, ok1, ok2;
   logic [ERR_W-1:0]           err0, err1, err2, best_err;
   logic                       any_ok;
   logic signed [SPOS_W-1:0]   bx_s, by_s;
   logic                       at_end, overshoot, fail;
   desc_type                   desc_in;

   assign req_chan.ready = (state_ff == W_IDLE) && !qstat.full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      fx_c = clamp_coord(req_chan.start_x);
      fy_c = clamp_coord(req_chan.start_y);
      tx_c = clamp_coord(req_chan.end_x);
      ty_c = clamp_coord(req_chan.end_y);

      px_s = $signed({{(SPOS_W-COORD_W){1'b0}}, px_ff});
      py_s = $signed({{(SPOS_W-COORD_W){1'b0}}, py_ff});
      tx_s = $signed({{(SPOS_W-COORD_W){1'b0}}, tx_ff});
      ty_s = $signed({{(SPOS_W-COORD_W){1'b0}}, ty_ff});
      sx_s = (dx_ff == '0) ? '0 : (dx_ff[DELTA_W-1] ? '1 : SPOS_W'(1));
      sy_s = (dy_ff == '0) ? '0 : (dy_ff[DELTA_W-1] ? '1 : SPOS_W'(1));
      x1_s = px_s + sx_s;
      y1_s = py_s + sy_s;

      // A move along an axis with no travel leaves the position unchanged.
      ok0  = (dx_ff != '0);
      ok1  = (dy_ff != '0);
      ok2  = ok0 || ok1;
      err0 = line_err(py_s - ty_s, x1_s - tx_s, dx_ff, dy_ff);
      err1 = line_err(y1_s - ty_s, px_s - tx_s, dx_ff, dy_ff);
      err2 = line_err(y1_s - ty_s, x1_s - tx_s, dx_ff, dy_ff);

      // Strict compare keeps the earlier move on a tie.
      any_ok   = 1'b0;
      best_err = '0;
      bx_s     = px_s;
      by_s     = py_s;
      if (ok0) begin
         any_ok   = 1'b1;
         best_err = err0;
         bx_s     = x1_s;
         by_s     = py_s;
      end
      if (ok1 && (!any_ok || err1 < best_err)) begin
         any_ok   = 1'b1;
         best_err = err1;
         bx_s     = px_s;
         by_s     = y1_s;
      end
      if (ok2 && (!any_ok || err2 < best_err)) begin
         any_ok   = 1'b1;
         best_err = err2;
         bx_s     = x1_s;
         by_s     = y1_s;
      end

      at_end    = (px_ff == tx_ff) && (py_ff == ty_ff);
      overshoot = (!dx_ff[DELTA_W-1] && dx_ff != '0 && bx_s > tx_s) ||
                  (dx_ff[DELTA_W-1] && bx_s < tx_s) ||
                  (!dy_ff[DELTA_W-1] && dy_ff != '0 && by_s > ty_s) ||
                  (dy_ff[DELTA_W-1] && by_s < ty_s);
      fail      = !any_ok || overshoot || (len_ff >= LEN_W'(LEN_LIMIT));

      push           = (state_ff == W_STEP) && (at_end || fail);
      desc_in.len    = len_ff;
      desc_in.failed = !at_end;
      desc_in.bank   = bank_ff;
      push_desc      = desc_in;

      wr_port.en   = 1'b0;
      wr_port.addr = {bank_ff, len_ff[IDX_W-1:0]};
      wr_port.data = {bx_s[COORD_W-1:0], by_s[COORD_W-1:0]};
      if (accept) begin
         wr_port.en   = 1'b1;
         wr_port.addr = {bank_ff, {IDX_W{1'b0}}};
         wr_port.data = {fx_c, fy_c};
      end else if (state_ff == W_STEP && !at_end && !fail) begin
         wr_port.en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         bank_ff  <= 1'b0;
      end else begin
         case (state_ff)
            W_IDLE: begin
               if (accept) begin
                  px_ff    <= fx_c;
                  py_ff    <= fy_c;
                  tx_ff    <= tx_c;
                  ty_ff    <= ty_c;
                  dx_ff    <= $signed({2'b00, tx_c}) - $signed({2'b00, fx_c});
                  dy_ff    <= $signed({2'b00, ty_c}) - $signed({2'b00, fy_c});
                  len_ff   <= LEN_W'(1);
                  state_ff <= W_STEP;
               end
            end
            W_STEP: begin
               if (push) begin
                  bank_ff  <= ~bank_ff;
                  state_ff <= W_IDLE;
               end else begin
                  px_ff  <= bx_s[COORD_W-1:0];
                  py_ff  <= by_s[COORD_W-1:0];
                  len_ff <= len_ff + LEN_W'(1);
               end
            end
            default: state_ff <= W_IDLE;
         endcase
      end
   end

endmodule

// ===== hw/rtl/ggl_queue.sv =====
// Short descriptor queue between the walker and the emitter, one slot per path bank.
// Depends on ggl_pkg.
module ggl_queue import ggl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  desc_type  push_desc,
   input  logic      pop,
   output desc_type  head,
   output qstat_type qstat
);

   desc_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign head        = slot_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule

// ===== hw/rtl/ggl_emitter.sv =====
// Back end: holds the two path banks and plays a finished path out on the response channel.
// Depends on ggl_pkg and ggl_chan_if; takes descriptors from ggl_queue.
module ggl_emitter import ggl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  wr_port_type wr_port,
   input  desc_type    head,
   input  qstat_type   qstat,
   output logic        pop,
   ggl_rsp_if.source   rsp_chan
);

   typedef enum logic [1:0] {E_IDLE, E_READ, E_SHOW} emit_state_type;

   cell_type         mem [MEM_DEPTH];
   cell_type         rd_data_ff;
   emit_state_type   state_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             last_ff;
   logic             failed_ff;
   logic             rd_en;

   assign rd_en = (state_ff == E_READ);
   assign pop   = (state_ff == E_SHOW) && rsp_chan.ready && last_ff;

   assign rsp_chan.valid  = (state_ff == E_SHOW);
   assign rsp_chan.cell_x = failed_ff ? '0 : rd_data_ff.x;
   assign rsp_chan.cell_y = failed_ff ? '0 : rd_data_ff.y;
   assign rsp_chan.last   = last_ff;
   assign rsp_chan.failed = failed_ff;

   always_ff @(posedge clock) begin
      if (wr_port.en) begin
         mem[wr_port.addr] <= wr_port.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[{head.bank, idx_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= E_IDLE;
         last_ff   <= 1'b0;
         failed_ff <= 1'b0;
      end else begin
         case (state_ff)
            E_IDLE: begin
               if (!qstat.empty) begin
                  idx_ff <= '0;
                  if (head.failed) begin
                     failed_ff <= 1'b1;
                     last_ff   <= 1'b1;
                     state_ff  <= E_SHOW;
                  end else begin
                     state_ff <= E_READ;
                  end
               end
            end
            E_READ: begin
               failed_ff <= 1'b0;
               last_ff   <= (LEN_W'(idx_ff) + LEN_W'(1)) == head.len;
               state_ff  <= E_SHOW;
            end
            E_SHOW: begin
               if (rsp_chan.ready) begin
                  if (last_ff) begin
                     state_ff <= E_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + IDX_W'(1);
                     state_ff <= E_READ;
                  end
               end
            end
            default: state_ff <= E_IDLE;
         endcase
      end
   end

endmodule

// ===== hw/rtl/greedy_grid_line_walk_unit.sv =====
// Greedy grid line walk unit. The walker writes the start cell of a path in the accept cycle and
// then one cell per cycle; the emitter reads each cell from the path memory and then shows it,
// holding it while rsp ready is low. Sustained throughput is set by the emitter, with the walk of
// the next line overlapped. A failed line skips the memory read and is shown from its descriptor.
// Reset is synchronous and clears all control state; the path memory is not cleared.
module greedy_grid_line_walk_unit import ggl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ggl_req_if.sink   req_chan,
   ggl_rsp_if.source rsp_chan
);

   // The walker accepts a request only when a path bank is free, that is when the
   // descriptor queue holds fewer entries than there are banks. It writes the start
   // cell in the accept cycle and one further cell per cycle, then pushes a
   // descriptor with the path length and the bank, or a failure mark as soon as a
   // step would pass the end cell or the path would exceed the length limit.
   qstat_type   qstat;
   desc_type    push_desc;
   desc_type    head;
   wr_port_type wr_port;
   logic        push;
   logic        pop;

   ggl_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .qstat     (qstat),
      .push      (push),
      .push_desc (push_desc),
      .wr_port   (wr_port)
   );

   // The head descriptor stays in the queue while its path is played out, so the
   // queue count is also the number of banks holding a finished path.
   ggl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   // The emitter reads the head bank one cell at a time and retires the descriptor
   // when the response marked last is taken.
   ggl_emitter u_emitter (
      .clock    (clock),
      .reset    (reset),
      .wr_port  (wr_port),
      .head     (head),
      .qstat    (qstat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // A descriptor is never pushed into a full queue.
   assert property (@(posedge clock) disable iff (reset) push |-> !qstat.full)
      else $error("descriptor pushed into a full queue");

   // The walker never writes the bank that the emitter is playing out.
   assert property (@(posedge clock) disable iff (reset)
      (wr_port.en && !qstat.empty) |-> (wr_port.addr[MEM_ADDR_W-1] != head.bank))
      else $error("walker wrote into the bank being emitted");

   // A failed line is a single last response with a zero cell.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.failed) |->
      (rsp_chan.last && rsp_chan.cell_x == '0 && rsp_chan.cell_y == '0))
      else $error("failed response not a single zero cell");

   // Once the last response of a line is taken, the channel goes quiet.
   assert property (@(posedge clock) disable iff (reset) pop |=> !rsp_chan.valid)
      else $error("response valid right after the line was retired");

endmodule

// ===== tb/greedy_grid_line_walk_unit_tb.sv =====
// Self-checking testbench for the greedy grid line walk unit.
// Depends on ggl_pkg, the ggl_req_if / ggl_rsp_if interfaces and greedy_grid_line_walk_unit.
`timescale 1ns / 1ps

module greedy_grid_line_walk_unit_tb;
   import ggl_pkg::*;

   // One expected path cell, tagged with the request that produced it so a
   // mismatch can be traced back to its line.
   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
      logic      failed;
      int        line_id;
   } path_cell_type;

   // Move set of the walker, in the order used to break ties.
   typedef enum int {
      MOVE_X    = 0,
      MOVE_Y    = 1,
      MOVE_DIAG = 2
   } move_type;

   logic clock = 1'b0;
   logic reset;

   ggl_req_if req_chan ();
   ggl_rsp_if rsp_chan ();

   greedy_grid_line_walk_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   path_cell_type expected_cells[$];
   int            mismatch_count = 0;
   int            line_count     = 0;
   int            stall_left     = 0;
   // When clear, neither the request side nor the response side idles, so
   // some stretches run at full rate.
   bit            idle_enable    = 1'b0;

   // Idle length in cycles: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_enable || roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Walks one line exactly as the unit is specified to and queues the cells
   // it should emit. The walk picks, among the x, y and diagonal moves toward
   // the end, the one closest to the ideal line; a step that carries either
   // coordinate past its end coordinate means the walk can never finish. That, or
   // a path too long to store, collapses the line to a single failed response.
   function automatic void walk_line_cells(input coord_type from_x, input coord_type from_y,
                                           input coord_type to_x, input coord_type to_y);
      int            fx, fy, tx, ty;
      int            dx, dy, sx, sy;
      int            px, py, bx, by, cx, cy;
      int            err, best_err;
      int            best;
      bit            overshoot;
      path_cell_type visit;
      path_cell_type walked[$];

      // Coordinates at or above the grid side saturate; with a 4-bit field
      // and a 16-cell grid this never bites, but the rule stays in place.
      fx = (int'(from_x) >= GRID_SIDE) ? GRID_SIDE - 1 : int'(from_x);
      fy = (int'(from_y) >= GRID_SIDE) ? GRID_SIDE - 1 : int'(from_y);
      tx = (int'(to_x) >= GRID_SIDE) ? GRID_SIDE - 1 : int'(to_x);
      ty = (int'(to_y) >= GRID_SIDE) ? GRID_SIDE - 1 : int'(to_y);
      dx = tx - fx;
      dy = ty - fy;
      sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
      sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
      px = fx;
      py = fy;
      overshoot = 1'b0;

      visit.last    = 1'b0;
      visit.failed  = 1'b0;
      visit.line_id = line_count;
      visit.x       = coord_type'(px);
      visit.y       = coord_type'(py);
      walked.insert(walked.size(), visit);

      while (!(px == tx && py == ty)) begin
         best     = -1;
         best_err = 0;
         bx       = px;
         by       = py;
         for (int m = MOVE_X; m <= MOVE_DIAG; m++) begin
            cx = px + ((m == MOVE_Y) ? 0 : sx);
            cy = py + ((m == MOVE_X) ? 0 : sy);
            // A move along an axis with no delta goes nowhere.
            if (cx == px && cy == py)
               continue;
            err = (cy - ty) * dx - (cx - tx) * dy;
            if (err < 0)
               err = -err;
            // Strict compare keeps the earlier move on a tie.
            if (best < 0 || err < best_err) begin
               best     = m;
               best_err = err;
               bx       = cx;
               by       = cy;
            end
         end
         px = bx;
         py = by;
         if (best < 0 || (sx > 0 && px > tx) || (sx < 0 && px < tx) ||
             (sy > 0 && py > ty) || (sy < 0 && py < ty) ||
             walked.size() >= STORE_DEPTH || walked.size() >= GIVE_UP_POSITIONS) begin
            overshoot = 1'b1;
            break;
         end
         visit.x = coord_type'(px);
         visit.y = coord_type'(py);
         walked.insert(walked.size(), visit);
      end

      if (overshoot) begin
         visit.x      = '0;
         visit.y      = '0;
         visit.last   = 1'b1;
         visit.failed = 1'b1;
         expected_cells.insert(expected_cells.size(), visit);
      end else begin
         walked[walked.size() - 1].last = 1'b1;
         foreach (walked[i])
            expected_cells.insert(expected_cells.size(), walked[i]);
      end
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   // Sends one line request. Inputs change on the falling edge; the request
   // counts as taken at the first rising edge that sees ready high, and the
   // expected path is queued right there.
   task automatic send_line(input coord_type from_x, input coord_type from_y,
                            input coord_type to_x, input coord_type to_y);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.start_x = from_x;
      req_chan.start_y = from_y;
      req_chan.end_x   = to_x;
      req_chan.end_y   = to_y;
      do
         @(posedge clock);
      while (!req_chan.ready);
      walk_line_cells(from_x, from_y, to_x, to_y);
      line_count++;
   endtask

   // Response side backpressure: after each cycle with ready high, a stall
   // of random length may follow.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready = 1'b1;
         stall_left = pick_gap();
      end
   end

   // Every accepted response is checked field by field against the oldest
   // expected cell.
   always @(posedge clock) begin : check_responses
      path_cell_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_cells.size() == 0) begin
            report_mismatch($sformatf(
               "response with nothing expected: x=%0d y=%0d last=%0b failed=%0b",
               rsp_chan.cell_x, rsp_chan.cell_y, rsp_chan.last, rsp_chan.failed));
         end else begin
            want = expected_cells.pop_front();
            if (rsp_chan.cell_x !== want.x)
               report_mismatch($sformatf("line %0d cell_x got %0d want %0d",
                                         want.line_id, rsp_chan.cell_x, want.x));
            if (rsp_chan.cell_y !== want.y)
               report_mismatch($sformatf("line %0d cell_y got %0d want %0d",
                                         want.line_id, rsp_chan.cell_y, want.y));
            if (rsp_chan.last !== want.last)
               report_mismatch($sformatf("line %0d last got %0b want %0b",
                                         want.line_id, rsp_chan.last, want.last));
            if (rsp_chan.failed !== want.failed)
               report_mismatch($sformatf("line %0d failed got %0b want %0b",
                                         want.line_id, rsp_chan.failed, want.failed));
         end
      end
   end

   // A line whose start equals its end is a single cell marked last.
   task automatic test_single_cell();
      send_line(4'd0, 4'd0, 4'd0, 4'd0);
      send_line(4'd15, 4'd15, 4'd15, 4'd15);
      send_line(4'd7, 4'd9, 4'd7, 4'd9);
   endtask

   // Pure horizontal and vertical lines across the full grid, both ways.
   task automatic test_axis_lines();
      send_line(4'd0, 4'd5, 4'd15, 4'd5);
      send_line(4'd15, 4'd5, 4'd0, 4'd5);
      send_line(4'd3, 4'd0, 4'd3, 4'd15);
      send_line(4'd3, 4'd15, 4'd3, 4'd0);
   endtask

   // Full-length diagonals corner to corner.
   task automatic test_diagonals();
      send_line(4'd0, 4'd0, 4'd15, 4'd15);
      send_line(4'd15, 4'd15, 4'd0, 4'd0);
      send_line(4'd0, 4'd15, 4'd15, 4'd0);
      send_line(4'd15, 4'd0, 4'd0, 4'd15);
   endtask

   // Shallow and steep lines in six of the eight octants, where ties between moves and
   // the choice of the minor step matter most.
   task automatic test_octants();
      send_line(4'd0, 4'd0, 4'd15, 4'd7);
      send_line(4'd2, 4'd3, 4'd9, 4'd14);
      send_line(4'd14, 4'd2, 4'd3, 4'd6);
      send_line(4'd10, 4'd12, 4'd4, 4'd1);
      send_line(4'd1, 4'd13, 4'd12, 4'd8);
      send_line(4'd6, 4'd15, 4'd9, 4'd0);
   endtask

   // Lines whose minor delta is one: the greedy pick is most apt to run past
   // the end coordinate here, which must show up as one failed response.
   task automatic test_overshoot_candidates();
      send_line(4'd0, 4'd0, 4'd15, 4'd1);
      send_line(4'd15, 4'd1, 4'd0, 4'd0);
      send_line(4'd0, 4'd0, 4'd1, 4'd15);
      send_line(4'd1, 4'd15, 4'd0, 4'd0);
      send_line(4'd15, 4'd14, 4'd0, 4'd15);
      send_line(4'd14, 4'd0, 4'd15, 4'd15);
   endtask

   // Random lines: mostly anywhere on the grid, a good share short so that
   // requests queue up behind the emitter, and a few single cells.
   task automatic test_random_lines(input int count);
      coord_type from_x, from_y, to_x, to_y;
      int        roll, ex, ey;
      for (int n = 0; n < count; n++) begin
         roll   = $urandom_range(0, 99);
         from_x = coord_type'($urandom_range(0, GRID_SIDE - 1));
         from_y = coord_type'($urandom_range(0, GRID_SIDE - 1));
         if (roll < 5) begin
            to_x = from_x;
            to_y = from_y;
         end else if (roll < 30) begin
            ex   = int'(from_x) + $urandom_range(0, 6) - 3;
            ey   = int'(from_y) + $urandom_range(0, 6) - 3;
            to_x = coord_type'((ex < 0) ? 0 : ((ex >= GRID_SIDE) ? GRID_SIDE - 1 : ex));
            to_y = coord_type'((ey < 0) ? 0 : ((ey >= GRID_SIDE) ? GRID_SIDE - 1 : ey));
         end else begin
            to_x = coord_type'($urandom_range(0, GRID_SIDE - 1));
            to_y = coord_type'($urandom_range(0, GRID_SIDE - 1));
         end
         send_line(from_x, from_y, to_x, to_y);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.start_x = '0;
      req_chan.start_y = '0;
      req_chan.end_x   = '0;
      req_chan.end_y   = '0;
      rsp_chan.ready   = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The first directed lines and the middle batch of random lines go
      // through back to back, the rest with idling on both sides.
      test_single_cell();
      test_axis_lines();
      idle_enable = 1'b1;
      test_diagonals();
      test_octants();
      test_overshoot_candidates();

      test_random_lines(150);
      idle_enable = 1'b0;
      test_random_lines(100);
      idle_enable = 1'b1;
      test_random_lines(150);

      @(negedge clock);
      req_chan.valid = 1'b0;

      // Drain: wait for every queued cell, then give the unit time to show
      // anything extra it might still emit.
      while (expected_cells.size() != 0)
         @(posedge clock);
      idle_enable = 1'b0;
      repeat (100) @(posedge clock);

      if (mismatch_count == 0)
         $display("greedy_grid_line_walk_unit_tb: PASS");
      else
         $display("greedy_grid_line_walk_unit_tb: FAIL");
      $finish;
   end

   // Watchdog: well beyond the slowest correct run, where every response
   // waits out a long stall.
   initial begin
      #50_000_000;
      $display("greedy_grid_line_walk_unit_tb: FAIL");
      $finish;
   end

endmodule
